>>> rtl/core/multichannel_moving_average_core_assert.svh
// assertion helpers for the moving average core
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MMA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define MMA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mma_pkg.sv
`default_nettype none

package mma_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int SLOT_W     = 2;
	localparam int WIN_W      = 5;
	localparam int CFG_IDX_W  = 3;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [WIN_W-1:0]  win_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam win_t WIN_RESET = 5'd16;

	// register indexes
	localparam cfg_idx_t REG_WIN_BATT_VOLT  = 3'd0;
	localparam cfg_idx_t REG_WIN_PANEL_VOLT = 3'd1;
	localparam cfg_idx_t REG_WIN_BATT_CURR  = 3'd2;
	localparam cfg_idx_t REG_WIN_PANEL_CURR = 3'd3;

	// slot numbers
	localparam slot_t SLOT_BATT_VOLT  = 2'd0;
	localparam slot_t SLOT_PANEL_VOLT = 2'd1;
	localparam slot_t SLOT_BATT_CURR  = 2'd2;
	localparam slot_t SLOT_PANEL_CURR = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/multichannel_moving_average_core.sv
// channel   dir  handshake                 payload
// sample    in   sample_valid/sample_stall sample
// result    out  result_valid/result_stall served_slot, new_average, four slot averages
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// a sample is taken only after the last item is done; an item, W the slot's effective window,
// is the transfer, one store write, W reads and the drain of the read port, a restoring
// divider that retires one quotient bit a cycle, and one result load
// after reset a clearing pass zeroes the store, 4 * 2^ceil(log2(min(MAX_WINDOW, 31)))
// entries (64 by default); samples are stalled until it ends, cfg writes are taken
// a finished result sits in the output register; the next sample is taken meanwhile,
// and the core only waits at the end of an item while that register is still full
`default_nettype none

`include "multichannel_moving_average_core_assert.svh"

module multichannel_moving_average_core
	import mma_pkg::*;
#(
	parameter int MAX_WINDOW  = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire logic [SAMPLE_BITS-1:0] sample,

	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [SLOT_W-1:0]           served_slot,
	output logic [SAMPLE_BITS-1:0]      new_average,
	output logic [SAMPLE_BITS-1:0]      battery_voltage_avg,
	output logic [SAMPLE_BITS-1:0]      panel_voltage_avg,
	output logic [SAMPLE_BITS-1:0]      battery_current_avg,
	output logic [SAMPLE_BITS-1:0]      panel_current_avg,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [WIN_W-1:0]       cfg_data
);

	localparam int   EFF_MAX_I = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
	localparam win_t EFF_MAX   = WIN_W'(EFF_MAX_I);
	localparam int   IDX_W     = (EFF_MAX_I > 1) ? $clog2(EFF_MAX_I) : 1;
	localparam int   ADDR_W    = SLOT_W + IDX_W;
	localparam int   DEPTH     = 1 << ADDR_W;
	localparam int   SUM_W     = SAMPLE_BITS + WIN_W;
	localparam int   DCNT_W    = $clog2(SUM_W + 1);
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WR   = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]             state_q;
	logic                   clr_q;
	logic [ADDR_W-1:0]      clr_addr_q;

	win_t                   window_q [SLOT_COUNT];
	logic [IDX_W-1:0]       pos_q    [SLOT_COUNT];
	logic [SAMPLE_BITS-1:0] avg_q    [SLOT_COUNT];
	slot_t                  ptr_q;

	// item being worked on
	slot_t                  slot_q;
	win_t                   w_q;
	logic [IDX_W-1:0]       wpos_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	logic [SAMPLE_BITS-1:0] store_mem [DEPTH];
	logic [SAMPLE_BITS-1:0] mem_rdata_q;
	logic                   rd_pend_q;
	win_t                   rd_cnt_q;
	logic [SUM_W-1:0]       acc_q;

	logic [WIN_W-1:0]       rem_q;
	logic [SUM_W-1:0]       dvd_q;
	logic [DCNT_W-1:0]      dcnt_q;

	logic                   result_valid_q;

	// comb
	win_t                   win_raw;
	win_t                   w_eff;
	logic [IDX_W-1:0]       pos_eff;
	logic                   in_xfer;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [WIN_W:0]         trial;
	logic                   ge;
	logic [WIN_W:0]         diff;
	logic [SUM_W-1:0]       dvd_next;
	win_t                   pos_inc;
	logic [IDX_W-1:0]       pos_next;
	logic                   out_free;

	always_comb begin
		win_raw = window_q[ptr_q];
		if (win_raw == '0) begin
			w_eff = WIN_W'(1);
		end else if (win_raw > EFF_MAX) begin
			w_eff = EFF_MAX;
		end else begin
			w_eff = win_raw;
		end
		// a shrunk window wraps the position before the write
		pos_eff = (WIN_W'(pos_q[ptr_q]) >= w_eff) ? '0 : pos_q[ptr_q];
	end

	assign sample_stall = !(state_q == S_IDLE && !clr_q);
	assign in_xfer      = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;

	assign mem_we    = clr_q || (state_q == S_WR);
	assign mem_waddr = clr_q ? clr_addr_q : {slot_q, wpos_q};
	assign mem_wdata = clr_q ? '0 : sample_q;

	assign rd_en   = (state_q == S_SUM) && (rd_cnt_q < w_q);
	assign rd_addr = {slot_q, rd_cnt_q[IDX_W-1:0]};

	assign trial    = {rem_q, dvd_q[SUM_W-1]};
	assign ge       = trial >= {1'b0, w_q};
	assign diff     = trial - {1'b0, w_q};
	assign dvd_next = {dvd_q[SUM_W-2:0], ge};

	assign pos_inc  = WIN_W'(wpos_q) + WIN_W'(1);
	assign pos_next = (pos_inc >= w_q) ? '0 : pos_inc[IDX_W-1:0];

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			mem_rdata_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				window_q[i] <= WIN_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIN_BATT_VOLT:  window_q[SLOT_BATT_VOLT]  <= cfg_data;
				REG_WIN_PANEL_VOLT: window_q[SLOT_PANEL_VOLT] <= cfg_data;
				REG_WIN_BATT_CURR:  window_q[SLOT_BATT_CURR]  <= cfg_data;
				REG_WIN_PANEL_CURR: window_q[SLOT_PANEL_CURR] <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture, accumulation and divider datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot_q   <= ptr_q;
			w_q      <= w_eff;
			wpos_q   <= pos_eff;
			sample_q <= sample;
		end
		if (state_q == S_WR) begin
			acc_q <= '0;
		end else if (rd_pend_q) begin
			acc_q <= acc_q + SUM_W'(mem_rdata_q);
		end
		if (state_q == S_SUM) begin
			rem_q <= '0;
			dvd_q <= acc_q;
		end else if (state_q == S_DIV) begin
			rem_q <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
			dvd_q <= dvd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_pend_q <= 1'b0;
			rd_cnt_q  <= '0;
			dcnt_q    <= '0;
			ptr_q     <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				pos_q[i] <= '0;
				avg_q[i] <= '0;
			end
		end else begin
			rd_pend_q <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					rd_cnt_q <= '0;
					state_q  <= S_SUM;
				end
				S_SUM: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else if (!rd_pend_q) begin
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIV_LAST) begin
						avg_q[slot_q] <= dvd_next[SAMPLE_BITS-1:0];
						pos_q[slot_q] <= pos_next;
						ptr_q         <= slot_q + 1'b1;
						state_q       <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			served_slot         <= slot_q;
			new_average         <= avg_q[slot_q];
			battery_voltage_avg <= avg_q[SLOT_BATT_VOLT];
			panel_voltage_avg   <= avg_q[SLOT_PANEL_VOLT];
			battery_current_avg <= avg_q[SLOT_BATT_CURR];
			panel_current_avg   <= avg_q[SLOT_PANEL_CURR];
		end
	end

	assign result_valid = result_valid_q;

	`MMA_ASSERT_NXT(a_accept_starts_write, in_xfer, state_q == S_WR,
		"accepted sample did not start a store write")
	`MMA_ASSERT_IMP(a_div_window_legal, state_q == S_DIV, w_q != '0 && w_q <= EFF_MAX,
		"divider running with an illegal window")
	`MMA_ASSERT_IMP(a_ptr_held_while_busy,
		state_q == S_WR || state_q == S_SUM || state_q == S_DIV, ptr_q == slot_q,
		"slot pointer moved before the item finished")
	`MMA_ASSERT_NXT(a_result_load, state_q == S_OUT && out_free,
		result_valid && served_slot == $past(slot_q),
		"result register not loaded with the served slot")

endmodule

`default_nettype wire
